// File: rtl/core/skts_pkg.sv
// Shared constants and codes for the sorted key table search block.
package skts_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_BITS    = 32;
	localparam int CYC_BITS    = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int REC_W       = KEY_BITS + CYC_BITS;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_RANGE  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED    = 3'd0,
		ST_FULL        = 3'd1,
		ST_FOUND       = 3'd2,
		ST_NOT_FOUND   = 3'd3,
		ST_RANGE_MATCH = 3'd4,
		ST_RANGE_EMPTY = 3'd5
	} status_t;

endpackage

// File: rtl/core/sorted_key_table_search.sv
// Sorted key table with insert, exact search and range search.
//
// Channel   Handshake          Fields
// request   start / busy       op, record_key, record_cycle, upper_bound
// result    done (1 cycle)     status, found_key, found_cycle, last
//
// A request is taken when start is high and busy is low; one request is
// worked on at a time. Records sit in one synchronous RAM (key, cycle)
// with a registered read. Every request but a full-table insert or op
// code 3 first runs a binary search: each halving step reads the middle
// entry (S_BS) and compares it (S_BS_CMP); S_BS ends it once the bounds meet.
// Insert then shifts the tail up one entry per cycle (read i-1, write i
// the next cycle), then writes the new record at its slot (S_INS).
// Range search streams one entry per cycle, results trail by one entry so
// that last can be set; exact search checks the slot it found (S_EX_CHK).
// A full-table insert answers in the cycle after acceptance; op code 3 is
// dropped. Reset (arst_n low) empties the table at once, no clearing pass:
// only entries below the count are ever read. The receiver cannot stall;
// each result is shown for exactly one cycle.
module sorted_key_table_search (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     op,
	input  logic [skts_pkg::KEY_BITS-1:0]  record_key,
	input  logic [skts_pkg::CYC_BITS-1:0]  record_cycle,
	input  logic [skts_pkg::KEY_BITS-1:0]  upper_bound,
	output logic                           done,
	output logic [2:0]                     status,
	output logic [skts_pkg::KEY_BITS-1:0]  found_key,
	output logic [skts_pkg::CYC_BITS-1:0]  found_cycle,
	output logic                           last
);
	import skts_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BS,
		S_BS_CMP,
		S_SHIFT,
		S_INS,
		S_EX_CHK,
		S_SCAN
	} state_t;

	state_t              state_q;
	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CYC_BITS-1:0] cycle_q;
	logic [KEY_BITS-1:0] upper_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    lo_q;
	logic [CNT_W-1:0]    hi_q;
	logic [IDX_W-1:0]    mid_q;
	logic [CNT_W-1:0]    idx_q;

	// shift pipeline: entry read last cycle is written one slot up
	logic                pend_s1;
	logic [IDX_W-1:0]    pend_addr_s1;

	// scan pipeline: read outstanding, plus one held match
	logic                v_s1;
	logic                have_q;
	logic [KEY_BITS-1:0] pk_q;
	logic [CYC_BITS-1:0] pc_q;

	// record RAM
	logic [REC_W-1:0]    rec_mem [TABLE_DEPTH];
	logic [REC_W-1:0]    rd_data_q;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [REC_W-1:0]    wr_data;

	logic [KEY_BITS-1:0] rd_key;
	logic [CYC_BITS-1:0] rd_cyc;
	logic [CNT_W:0]      mid_sum;
	logic [CNT_W-1:0]    mid;
	logic                go_right;
	logic                hit;
	logic                finish;

	assign busy    = (state_q != S_IDLE);
	assign rd_key  = rd_data_q[REC_W-1 -: KEY_BITS];
	assign rd_cyc  = rd_data_q[CYC_BITS-1:0];
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CNT_W:1];

	// insert and range search use an upper bound (first key > k),
	// exact search a lower bound (first key >= k)
	assign go_right = (op_q == OP_SEARCH) ? (rd_key < key_q) : (rd_key <= key_q);

	assign hit    = v_s1 && (rd_key < upper_q);
	assign finish = (v_s1 && !hit) || (!v_s1 && (idx_q >= cnt_q));

	// RAM read port
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid[IDX_W-1:0];
		case (state_q)
			S_BS: begin
				if (lo_q < hi_q) begin
					rd_en   = 1'b1;
					rd_addr = mid[IDX_W-1:0];
				end else if (op_q == OP_SEARCH && lo_q < cnt_q) begin
					rd_en   = 1'b1;
					rd_addr = lo_q[IDX_W-1:0];
				end
			end
			S_SHIFT: begin
				if (idx_q > lo_q) begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(idx_q - 1'b1);
				end
			end
			S_SCAN: begin
				if (idx_q < cnt_q) begin
					rd_en   = 1'b1;
					rd_addr = idx_q[IDX_W-1:0];
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// RAM write port: shifted entry, else the new record at its slot
	always_comb begin
		wr_en   = pend_s1 || (state_q == S_INS);
		wr_addr = pend_s1 ? pend_addr_s1 : lo_q[IDX_W-1:0];
		wr_data = pend_s1 ? rd_data_q : {key_q, cycle_q};
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rec_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= rec_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done    <= 1'b0;
			pend_s1 <= 1'b0;
			v_s1    <= 1'b0;
			have_q  <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= op;
						key_q   <= record_key;
						cycle_q <= record_cycle;
						upper_q <= upper_bound;
						lo_q    <= '0;
						hi_q    <= cnt_q;
						case (op)
							OP_INSERT: begin
								if (cnt_q >= CNT_W'(TABLE_DEPTH)) begin
									done        <= 1'b1;
									status      <= ST_FULL;
									found_key   <= '0;
									found_cycle <= '0;
									last        <= 1'b1;
								end else begin
									state_q <= S_BS;
								end
							end
							OP_SEARCH, OP_RANGE: begin
								state_q <= S_BS;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_BS: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid[IDX_W-1:0];
						state_q <= S_BS_CMP;
					end else begin
						case (op_q)
							OP_INSERT: begin
								idx_q   <= cnt_q;
								state_q <= S_SHIFT;
							end
							OP_SEARCH: begin
								if (lo_q < cnt_q) begin
									state_q <= S_EX_CHK;
								end else begin
									done        <= 1'b1;
									status      <= ST_NOT_FOUND;
									found_key   <= '0;
									found_cycle <= '0;
									last        <= 1'b1;
									state_q     <= S_IDLE;
								end
							end
							OP_RANGE: begin
								idx_q   <= lo_q;
								v_s1    <= 1'b0;
								have_q  <= 1'b0;
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_BS_CMP: begin
					if (go_right) begin
						lo_q <= CNT_W'({1'b0, mid_q} + 1'b1);
					end else begin
						hi_q <= {1'b0, mid_q};
					end
					state_q <= S_BS;
				end
				S_SHIFT: begin
					pend_s1      <= (idx_q > lo_q);
					pend_addr_s1 <= idx_q[IDX_W-1:0];
					if (idx_q > lo_q) begin
						idx_q <= idx_q - 1'b1;
					end else begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					cnt_q       <= cnt_q + 1'b1;
					done        <= 1'b1;
					status      <= ST_INSERTED;
					found_key   <= '0;
					found_cycle <= '0;
					last        <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_EX_CHK: begin
					done <= 1'b1;
					last <= 1'b1;
					if (rd_key == key_q) begin
						status      <= ST_FOUND;
						found_key   <= rd_key;
						found_cycle <= rd_cyc;
					end else begin
						status      <= ST_NOT_FOUND;
						found_key   <= '0;
						found_cycle <= '0;
					end
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					v_s1 <= (idx_q < cnt_q);
					if (idx_q < cnt_q) begin
						idx_q <= idx_q + 1'b1;
					end
					// a new match releases the held one as a non-final result
					if (hit) begin
						if (have_q) begin
							done        <= 1'b1;
							status      <= ST_RANGE_MATCH;
							found_key   <= pk_q;
							found_cycle <= pc_q;
							last        <= 1'b0;
						end
						pk_q   <= rd_key;
						pc_q   <= rd_cyc;
						have_q <= 1'b1;
					end
					if (finish) begin
						done <= 1'b1;
						last <= 1'b1;
						if (have_q) begin
							status      <= ST_RANGE_MATCH;
							found_key   <= pk_q;
							found_cycle <= pc_q;
						end else begin
							status      <= ST_RANGE_EMPTY;
							found_key   <= '0;
							found_cycle <= '0;
						end
						v_s1    <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// entry count never passes the table depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// shift writes happen only while shifting
	a_shift_wr: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == S_SHIFT))
		else $error("shift write outside shift phase");

	// an insert result comes with exactly one more entry
	a_ins_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_INSERTED) |-> (cnt_q == CNT_W'($past(cnt_q) + 1'b1)))
		else $error("insert did not grow the table by one");

	// an empty range is always a single, final result
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_RANGE_EMPTY) |-> (last && found_key == '0))
		else $error("empty range result malformed");

endmodule

// File: dv/tb_sorted_key_table_search.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted key table: directed and random requests.
module tb_sorted_key_table_search;
	import skts_pkg::*;

	// Op code 3 is outside the operation enum; the block drops it without a result.
	localparam logic [1:0]          OP_UNUSED    = 2'd3;
	localparam logic [KEY_BITS-1:0] KEY_MAX      = '1;
	// Worst request: a binary search plus a full shift or scan of the table.
	localparam int                  DRAIN_CYCLES = 100;
	localparam int                  CYCLE_LIMIT  = 400000;
	localparam int                  PHASE_ITEMS  = 32;

	typedef struct {
		status_t             status;
		logic [KEY_BITS-1:0] key;
		logic [CYC_BITS-1:0] cycle;
		logic                last;
	} table_result_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic                busy;
	logic [1:0]          op           = OP_INSERT;
	logic [KEY_BITS-1:0] record_key   = '0;
	logic [CYC_BITS-1:0] record_cycle = '0;
	logic [KEY_BITS-1:0] upper_bound  = '0;
	logic                done;
	logic [2:0]          status;
	logic [KEY_BITS-1:0] found_key;
	logic [CYC_BITS-1:0] found_cycle;
	logic                last;

	// Shadow copy of the table, kept sorted by ascending key.
	logic [KEY_BITS-1:0] key_table   [TABLE_DEPTH];
	logic [CYC_BITS-1:0] cycle_table [TABLE_DEPTH];
	int                  entry_total = 0;

	// Results still owed by the block, oldest first.
	table_result_t       expected_results [$];
	table_result_t       head_result;

	int                  idle_pct    = 0;
	int                  fail_count  = 0;
	int                  cycle_count = 0;

	sorted_key_table_search uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.record_key  (record_key),
		.record_cycle(record_cycle),
		.upper_bound (upper_bound),
		.done        (done),
		.status      (status),
		.found_key   (found_key),
		.found_cycle (found_cycle),
		.last        (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void push_result(status_t st, logic [KEY_BITS-1:0] k,
			logic [CYC_BITS-1:0] c, logic l);
		table_result_t r;
		r.status = st;
		r.key    = k;
		r.cycle  = c;
		r.last   = l;
		expected_results.insert(expected_results.size(), r);
	endfunction

	// Works out what one accepted request returns and updates the shadow table.
	function automatic void predict_request(logic [1:0] o, logic [KEY_BITS-1:0] k,
			logic [CYC_BITS-1:0] c, logic [KEY_BITS-1:0] ub);
		int pos;
		int n;
		pos = 0;
		n   = 0;
		case (o)
			OP_INSERT: begin
				if (entry_total >= TABLE_DEPTH) begin
					// full table: nothing changes
					push_result(ST_FULL, '0, '0, 1'b1);
				end else begin
					// goes after every equal key, so duplicates keep arrival order
					while (pos < entry_total && key_table[pos] <= k)
						pos++;
					for (int i = entry_total; i > pos; i--) begin
						key_table[i]   = key_table[i-1];
						cycle_table[i] = cycle_table[i-1];
					end
					key_table[pos]   = k;
					cycle_table[pos] = c;
					entry_total++;
					push_result(ST_INSERTED, '0, '0, 1'b1);
				end
			end
			OP_SEARCH: begin
				// first entry with key >= k, i.e. the oldest of any duplicates
				while (pos < entry_total && key_table[pos] < k)
					pos++;
				if (pos < entry_total && key_table[pos] == k)
					push_result(ST_FOUND, key_table[pos], cycle_table[pos], 1'b1);
				else
					push_result(ST_NOT_FOUND, '0, '0, 1'b1);
			end
			OP_RANGE: begin
				// both bounds exclusive
				while (pos < entry_total && key_table[pos] <= k)
					pos++;
				while (pos < entry_total && key_table[pos] < ub) begin
					push_result(ST_RANGE_MATCH, key_table[pos], cycle_table[pos],
						!(pos + 1 < entry_total && key_table[pos+1] < ub));
					pos++;
					n++;
				end
				if (n == 0)
					push_result(ST_RANGE_EMPTY, '0, '0, 1'b1);
			end
			default: begin
				// unused op: dropped, no result
			end
		endcase
	endfunction

	function automatic void check_field(string field, logic [KEY_BITS-1:0] want,
			logic [KEY_BITS-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h actual %h", $time, field, want, got);
			fail_count++;
		end
	endfunction

	// Result checker: every done strobe must match the oldest outstanding result.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display({"%0t: unexpected result: expected none ",
					"actual status %0d key %h cycle %h last %b"},
					$time, status, found_key, found_cycle, last);
				fail_count++;
			end else begin
				head_result = expected_results.pop_front();
				check_field("status", KEY_BITS'(head_result.status), KEY_BITS'(status));
				check_field("found_key", head_result.key, found_key);
				check_field("found_cycle", KEY_BITS'(head_result.cycle), KEY_BITS'(found_cycle));
				check_field("last", KEY_BITS'(head_result.last), KEY_BITS'(last));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_count, expected_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Sends one request and returns at the edge that took it, or after the idle
	// cycles that follow. start stays high when no idle cycle follows, so
	// back-to-back requests need no second NBA on start in the same step.
	task automatic send_request(logic [1:0] o, logic [KEY_BITS-1:0] k,
			logic [CYC_BITS-1:0] c, logic [KEY_BITS-1:0] ub);
		start        <= 1'b1;
		op           <= o;
		record_key   <= k;
		record_cycle <= c;
		upper_bound  <= ub;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_request(o, k, c, ub);
		// each following cycle is idle with the phase's odds
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Sender holds off until every outstanding result has come back.
	task automatic wait_all_results(int extra);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Keys: full random, a small pool (duplicates), stored keys (hits), extremes.
	function automatic logic [KEY_BITS-1:0] pick_key();
		logic [KEY_BITS-1:0] k;
		case ($urandom_range(3))
			0: k = $urandom();
			1: k = $urandom_range(0, 15);
			2: k = (entry_total > 0) ? key_table[$urandom_range(0, entry_total - 1)] : $urandom();
			default: k = $urandom_range(1) ? KEY_MAX : '0;
		endcase
		return k;
	endfunction

	task automatic send_random_request();
		int                  pick;
		logic [1:0]          o;
		logic [KEY_BITS-1:0] k;
		logic [KEY_BITS-1:0] ub;
		pick = $urandom_range(99);
		if (pick < 35)
			o = OP_INSERT;
		else if (pick < 65)
			o = OP_SEARCH;
		else if (pick < 95)
			o = OP_RANGE;
		else
			o = OP_UNUSED;
		k = pick_key();
		// mostly an upper bound above the lower one, sometimes inverted
		case ($urandom_range(3))
			0: ub = $urandom();
			1: ub = k + $urandom_range(1, 1 << 24);
			2: ub = pick_key();
			default: ub = KEY_MAX;
		endcase
		send_request(o, k, CYC_BITS'($urandom_range(16'hFFFF)), ub);
	endtask

	// Empty table: searches miss, range gives one empty result, op 3 is dropped.
	task automatic test_empty_table();
		idle_pct = 0;
		send_request(OP_SEARCH, '0, '0, '0);
		send_request(OP_RANGE, '0, '0, KEY_MAX);
		send_request(OP_UNUSED, 32'h1234_5678, 16'hBEEF, 32'h8765_4321);
		send_request(OP_SEARCH, 32'h1234_5678, 16'h0, 32'h0);
		wait_all_results(4);
	endtask

	// Extreme keys and cycles, three duplicates of one key in arrival order.
	task automatic test_insert_order();
		idle_pct = 0;
		send_request(OP_INSERT, KEY_MAX, 16'hFFFF, '0);
		send_request(OP_INSERT, '0, 16'h0000, KEY_MAX);
		send_request(OP_INSERT, 32'd5, 16'h0001, '0);
		send_request(OP_INSERT, 32'd5, 16'h0002, '0);
		send_request(OP_INSERT, 32'd5, 16'h0003, '0);
		send_request(OP_INSERT, 32'h8000_0000, 16'h8000, '0);
		send_request(OP_INSERT, 32'd2, 16'h7FFF, '0);
		wait_all_results(4);
	endtask

	// Hits on both extremes, first of duplicates, and misses.
	task automatic test_exact_search();
		idle_pct = 0;
		send_request(OP_SEARCH, '0, '0, '0);
		send_request(OP_SEARCH, KEY_MAX, '0, '0);
		send_request(OP_SEARCH, 32'd5, '0, '0);
		send_request(OP_SEARCH, 32'd4, '0, '0);
		send_request(OP_SEARCH, 32'h7FFF_FFFF, '0, '0);
		wait_all_results(4);
	endtask

	// Strict bounds on both sides, inverted and equal bounds give the empty result.
	task automatic test_range_search();
		idle_pct = 0;
		send_request(OP_RANGE, '0, '0, KEY_MAX);
		send_request(OP_RANGE, 32'd4, '0, 32'd6);
		send_request(OP_RANGE, 32'd5, '0, 32'd5);
		send_request(OP_RANGE, KEY_MAX, '0, '0);
		send_request(OP_RANGE, 32'd2, '0, 32'd5);
		send_request(OP_RANGE, 32'd1, '0, 32'h8000_0001);
		wait_all_results(4);
	endtask

	// Random mix in four idling phases; the sender drains between phases.
	task automatic test_random();
		int phase_idle [4] = '{0, 73, 0, 36};
		foreach (phase_idle[p]) begin
			idle_pct = phase_idle[p];
			repeat (PHASE_ITEMS) send_random_request();
			wait_all_results($urandom_range(1, 8));
		end
	endtask

	// Fill the table, then full-table inserts, searches on two stored keys and range searches.
	task automatic test_full_table();
		idle_pct = 36;
		while (entry_total < TABLE_DEPTH)
			send_request(OP_INSERT, pick_key(), CYC_BITS'($urandom_range(16'hFFFF)), $urandom());
		send_request(OP_INSERT, $urandom(), CYC_BITS'($urandom_range(16'hFFFF)), $urandom());
		send_request(OP_INSERT, KEY_MAX, 16'hFFFF, KEY_MAX);
		send_request(OP_INSERT, '0, 16'h0000, '0);
		send_request(OP_SEARCH, key_table[TABLE_DEPTH/2], '0, '0);
		send_request(OP_SEARCH, key_table[TABLE_DEPTH-1], '0, '0);
		// widest possible range over a full table
		send_request(OP_RANGE, '0, '0, KEY_MAX);
		send_request(OP_RANGE, 32'd3, '0, 32'd9);
		send_request(OP_RANGE, KEY_MAX, '0, KEY_MAX);
		send_request(OP_INSERT, 32'd7, 16'h5A5A, '0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_insert_order();
		test_exact_search();
		test_range_search();
		test_random();
		test_full_table();
		wait_all_results(DRAIN_CYCLES);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
